/* rtl/gnod_pkg.sv */
// ----------------------------------------------------------------------------
// gnod_pkg
// Shared types and constants for the nearest occupied distance unit.
// ----------------------------------------------------------------------------
package gnod_pkg;

  // Default edge length of the square grid.
  localparam int GRID_DEF = 10;

  // Action codes of an input item.
  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One input item.
  typedef struct packed {
    logic       action;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] run_length;
    logic       vertical;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       hit;
    logic [3:0] distance;
  } out_result_t;

  // Status of one evaluated row.
  typedef struct packed {
    logic any;   // At least one marked cell in the row.
    logic zero;  // The queried cell itself is marked.
  } row_flags_t;

endpackage

/* rtl/gnod_row_eval.sv */
// ----------------------------------------------------------------------------
// gnod_row_eval
// Shared row unit: Chebyshev distance from the query to the nearest marked
// cell of one occupancy row.
// ----------------------------------------------------------------------------
module gnod_row_eval
  import gnod_pkg::*;
#(
  parameter int GRID = GRID_DEF,
  localparam int IW  = $clog2(GRID),
  localparam int DW  = $clog2(GRID + 16)
) (
  input  logic [GRID-1:0] row_bits,
  input  logic [IW-1:0]   row_idx,
  input  logic [3:0]      q_row,
  input  logic [3:0]      q_col,
  output logic [DW-1:0]   near_dist,
  output row_flags_t      flags
);

  logic [DW-1:0] qr;
  logic [DW-1:0] qc;
  logic [DW-1:0] r;
  logic [DW-1:0] dr;
  logic [DW-1:0] lo_c;
  logic [DW-1:0] hi_c;
  logic [DW-1:0] dcl;
  logic [DW-1:0] dch;
  logic [DW-1:0] dc;
  logic          lo_found;
  logic          hi_found;

  // Nearest marked column at or left of the query, and at or right of it.
  always_comb begin
    qr = DW'(q_row);
    qc = DW'(q_col);
    r  = DW'(row_idx);
    dr = (r >= qr) ? (r - qr) : (qr - r);

    lo_found = 1'b0;
    lo_c     = '0;
    for (int c = 0; c < GRID; c++) begin
      if (row_bits[c] && (DW'(c) <= qc)) begin
        lo_found = 1'b1;
        lo_c     = DW'(c);
      end
    end

    hi_found = 1'b0;
    hi_c     = '0;
    for (int c = GRID - 1; c >= 0; c--) begin
      if (row_bits[c] && (DW'(c) >= qc)) begin
        hi_found = 1'b1;
        hi_c     = DW'(c);
      end
    end

    dcl = qc - lo_c;
    dch = hi_c - qc;
    dc  = (lo_found && (!hi_found || (dcl <= dch))) ? dcl : dch;

    near_dist  = (dr > dc) ? dr : dc;
    flags.any  = lo_found | hi_found;
    flags.zero = (lo_found | hi_found) && (near_dist == '0);
  end

endmodule

/* rtl/grid_nearest_occupied_distance_unit.sv */
// ----------------------------------------------------------------------------
// grid_nearest_occupied_distance_unit
// Occupancy grid with run placement and nearest marked cell queries.
// ----------------------------------------------------------------------------
// Timing: a query scans one occupancy row per cycle through the shared row
//   unit; the result strobe comes in the cycle after the last row is scanned.
// Placement marks one cell per cycle over run_length steps (cells beyond the grid are skipped); no result.
// Flow: a new item is taken only while idle; the next item may start while
//   the result strobe is shown, and the receiver cannot stall.
// Reset: synchronous, active low; clears the whole grid and the sequencer.
// ----------------------------------------------------------------------------
module grid_nearest_occupied_distance_unit
  import gnod_pkg::*;
#(
  parameter int GRID = GRID_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_result_t out_result
);

  localparam int IW   = $clog2(GRID);
  localparam int DW   = $clog2(GRID + 16);
  localparam int CNTW = (IW > 4) ? IW : 4;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PLACE = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   best_r, best_nxt;
  logic            hit_r, hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_result_t     out_result_r, out_result_nxt;
  in_item_t        item_r;

  logic [GRID-1:0] occ_r [GRID];

  logic [DW-1:0]   pr;
  logic [DW-1:0]   pc;
  logic            place_we;
  logic [DW-1:0]   row_dist;
  row_flags_t      row_flags;
  logic [DW-1:0]   best_upd;
  logic            hit_upd;
  logic            accept;

  assign accept = start && (state_r == S_IDLE);

  // Shared row distance unit, fed one row per scan cycle.
  gnod_row_eval #(
    .GRID (GRID)
  ) u_row_eval (
    .row_bits  (occ_r[cnt_r[IW-1:0]]),
    .row_idx   (cnt_r[IW-1:0]),
    .q_row     (item_r.row),
    .q_col     (item_r.col),
    .near_dist (row_dist),
    .flags     (row_flags)
  );

  // Fold the current row into the running best distance and hit flag.
  always_comb begin
    best_upd = best_r;
    if (row_flags.any && (row_dist != '0) && (row_dist <= DW'(GRID)) &&
        (row_dist < best_r)) begin
      best_upd = row_dist;
    end
    hit_upd = hit_r | row_flags.zero;
  end

  // Cell addressed by the current step of a placement.
  always_comb begin
    pr = item_r.vertical ? (DW'(item_r.row) + DW'(cnt_r[3:0])) : DW'(item_r.row);
    pc = item_r.vertical ? DW'(item_r.col) : (DW'(item_r.col) + DW'(cnt_r[3:0]));
    place_we = (state_r == S_PLACE) && (pr < DW'(GRID)) && (pc < DW'(GRID));
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    best_nxt       = best_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt  = '0;
          best_nxt = DW'(GRID + 1);
          hit_nxt  = 1'b0;
          if (in_item.action == ACT_QUERY) begin
            state_nxt = S_SCAN;
          end else if (in_item.run_length != 4'd0) begin
            state_nxt = S_PLACE;
          end
        end
      end
      S_PLACE: begin
        cnt_nxt = cnt_r + 1'b1;
        if ((cnt_r + 1'b1) == CNTW'(item_r.run_length)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cnt_nxt  = cnt_r + 1'b1;
        best_nxt = best_upd;
        hit_nxt  = hit_upd;
        if (cnt_r == CNTW'(GRID - 1)) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_result_nxt.hit      = hit_upd;
          out_result_nxt.distance = hit_upd ? 4'd0 : best_upd[3:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    best_r       <= best_nxt;
    hit_r        <= hit_nxt;
    out_result_r <= out_result_nxt;
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Occupancy bitmap, cleared by reset, one cell marked per placement step inside the grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GRID; i++) begin
        occ_r[i] <= '0;
      end
    end else if (place_we) begin
      occ_r[pr[IW-1:0]][pc[IW-1:0]] <= 1'b1;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest occupied distance unit. A queue of
// placements and queries is sent through the start/busy command port with
// random gaps. A local copy of the occupancy grid predicts the hit flag and
// the Chebyshev distance of every query, and each result strobe is checked.
// ----------------------------------------------------------------------------
module tb_top;
  import gnod_pkg::*;

  localparam int GRID       = GRID_DEF;
  localparam int CYCLE_CAP  = 300000;
  localparam int TAIL_WAIT  = 2 * GRID + 20;
  localparam int N_RANDOM   = 500;

  // One queued command with an optional wait for outstanding results.
  typedef struct packed {
    in_item_t item;
    logic     drain;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_result_t out_result;

  pending_t    pending_items[$];
  out_result_t owed_results[$];
  logic [GRID-1:0] occ_map [GRID];
  int          fail_count = 0;
  int          gap_left = 0;
  int          quiet_left = 0;
  int          cycle_count = 0;

  grid_nearest_occupied_distance_unit #(
    .GRID(GRID)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always #5 clk = ~clk;

  // Shortest Chebyshev distance from a position to a marked cell, capped.
  function automatic logic [3:0] nearest_mark_distance(int qr, int qc);
    int best;
    int dr;
    int dc;
    int d;
    best = GRID + 1;
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        if (occ_map[r][c]) begin
          dr = (r >= qr) ? r - qr : qr - r;
          dc = (c >= qc) ? c - qc : qc - c;
          d = (dr > dc) ? dr : dc;
          if (d >= 1 && d <= GRID && d < best) best = d;
        end
      end
    end
    return best[3:0];
  endfunction

  // Update the grid copy for one accepted command and, for a query, owe its result.
  function automatic void track_item(in_item_t it);
    int r;
    int c;
    out_result_t res;
    if (it.action == ACT_PLACE) begin
      for (int k = 0; k < int'(it.run_length); k++) begin
        r = it.vertical ? int'(it.row) + k : int'(it.row);
        c = it.vertical ? int'(it.col) : int'(it.col) + k;
        if (r < GRID && c < GRID) occ_map[r][c] = 1'b1;
      end
    end else begin
      if (it.row < GRID && it.col < GRID && occ_map[it.row][it.col]) begin
        res.hit = 1'b1;
        res.distance = 4'd0;
      end else begin
        res.hit = 1'b0;
        res.distance = nearest_mark_distance(int'(it.row), int'(it.col));
      end
      owed_results.push_back(res);
    end
  endfunction

  function automatic in_item_t make_item(logic act, int r, int c, int len, logic vert);
    in_item_t it;
    it.action = act;
    it.row = r[3:0];
    it.col = c[3:0];
    it.run_length = len[3:0];
    it.vertical = vert;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it, logic drain);
    pending_t p;
    p.item = it;
    p.drain = drain;
    pending_items.push_back(p);
  endfunction

  // Random pause after a transfer: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: records each transfer, then holds, idles or presents the next command.
  always @(posedge clk) begin
    pending_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        track_item(in_item);
        if (quiet_left > 0) begin
          quiet_left--;
          gap_left = 0;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 60);
        end
      end
      if (start && busy) begin
        // Command not taken yet; keep it on the port.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (pending_items[0].drain && owed_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        in_item <= nxt.item;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobe must match the oldest owed result.
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result hit=%0b distance=%0d", $time,
                 out_result.hit, out_result.distance);
      end else begin
        want = owed_results.pop_front();
        if (out_result.hit !== want.hit || out_result.distance !== want.distance) begin
          fail_count++;
          if (fail_count <= 30)
            $display("%0t: mismatch expected hit=%0b distance=%0d, got hit=%0b distance=%0d",
                     $time, want.hit, want.distance, out_result.hit, out_result.distance);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    int c;
    int len;
    int p;
    // The grid copy starts empty, as the block does after reset.
    for (int i = 0; i < GRID; i++) occ_map[i] = '0;

    // Directed: empty board, far positions, clipped and empty runs.
    queue_item(make_item(ACT_QUERY, 0, 0, 1, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 15, 15, 15, 1'b1), 1'b0);
    queue_item(make_item(ACT_PLACE, 0, 0, 10, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 0, 5, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 9, 9, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 10, 5, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 15, 0, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 11, 3, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 4, 4, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 4, 4, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 5, 8, 5, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 5, 9, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 5, 12, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 7, 3, 6, 1'b1), 1'b0);
    queue_item(make_item(ACT_QUERY, 9, 3, 0, 1'b0), 1'b1);
    queue_item(make_item(ACT_QUERY, 12, 3, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 12, 2, 4, 1'b1), 1'b0);
    queue_item(make_item(ACT_QUERY, 13, 2, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 15, 15, 15, 1'b1), 1'b0);
    queue_item(make_item(ACT_QUERY, 15, 15, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 6, 6, 0, 1'b0), 1'b0);
    queue_item(make_item(ACT_PLACE, 9, 0, 1, 1'b0), 1'b0);
    queue_item(make_item(ACT_QUERY, 9, 0, 0, 1'b0), 1'b1);

    // Random: mostly queries so the grid stays sparse; short runs, some clipped.
    for (int i = 0; i < N_RANDOM; i++) begin
      p = $urandom_range(0, 99);
      if (p < 9) begin
        r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 9) : $urandom_range(10, 15);
        c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 9) : $urandom_range(10, 15);
        p = $urandom_range(0, 9);
        if (p < 7) len = $urandom_range(1, 3);
        else if (p < 9) len = $urandom_range(4, 10);
        else len = $urandom_range(0, 15);
        queue_item(make_item(ACT_PLACE, r, c, len, 1'($urandom_range(0, 1))), 1'b0);
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          r = $urandom_range(0, 9);
          c = $urandom_range(0, 9);
        end else begin
          r = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end
        queue_item(make_item(ACT_QUERY, r, c, $urandom_range(0, 15),
                             1'($urandom_range(0, 1))),
                   (i % 150) == 75);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all transfers and results, then a quiet tail.
    @(posedge clk);
    while (pending_items.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (owed_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, owed_results.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
